// ===== src/idea_cbc_decryptor_assert.svh =====
// Assertion macros for the IDEA CBC decryptor checker.
// Each macro expands to one labeled concurrent assertion on i_clk,
// held off while i_rst_n is low.
`ifndef IDEA_CBC_DECRYPTOR_ASSERT_SVH
`define IDEA_CBC_DECRYPTOR_ASSERT_SVH

// Same-cycle implication.
`define ICD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icd assertion failed");

// Next-cycle implication.
`define ICD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icd assertion failed");

`endif

// ===== src/icd_pkg.sv =====
// ----------------------------------------------------------------------------
// icd_pkg
// Shared types, constants and arithmetic helpers for the IDEA CBC decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package icd_pkg;

    localparam int KEY_CNT   = 52;
    localparam int KEY_AW    = $clog2(KEY_CNT);
    localparam int CFG_IDX_W = 2;
    localparam int BLK_W     = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_HI = 2'd0;
    localparam t_cfg_idx CFG_KEY_LO = 2'd1;
    localparam t_cfg_idx CFG_IV     = 2'd2;

    typedef enum logic [2:0] {
        ST_KEY,
        ST_INV,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KOP_PLAIN,
        KOP_NEG,
        KOP_INV
    } t_kop;

    // Multiply mod 65537 with zero standing for 2^16.
    function automatic logic [15:0] f_gmul(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        logic [15:0] hi;
        logic [15:0] lo;
        begin
            p  = a * b;
            hi = p[31:16];
            lo = p[15:0];
            if (a == 16'h0000) begin
                f_gmul = 16'h0001 - b;
            end else if (b == 16'h0000) begin
                f_gmul = 16'h0001 - a;
            end else if (lo >= hi) begin
                f_gmul = lo - hi;
            end else begin
                f_gmul = lo - hi + 16'h0001;
            end
        end
    endfunction

    // Encryption subkey number idx of the 128-bit key.
    function automatic logic [15:0] f_ek(input logic [127:0] k, input logic [5:0] idx);
        logic [127:0] rk;
        begin
            case (idx[5:3])
                3'd0:    rk = k;
                3'd1:    rk = (k << 25)  | (k >> 103);
                3'd2:    rk = (k << 50)  | (k >> 78);
                3'd3:    rk = (k << 75)  | (k >> 53);
                3'd4:    rk = (k << 100) | (k >> 28);
                3'd5:    rk = (k << 125) | (k >> 3);
                3'd6:    rk = (k << 22)  | (k >> 106);
                default: rk = k;
            endcase
            f_ek = 16'(rk >> {~idx[2:0], 4'b0000});
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/icd_ram.sv =====
// ----------------------------------------------------------------------------
// icd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module icd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 52
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/idea_cbc_decryptor.sv =====
// ----------------------------------------------------------------------------
// idea_cbc_decryptor
// IDEA block decryption in CBC mode, 128-bit key, subkeys held in a RAM.
// ----------------------------------------------------------------------------
// After reset and after every write to a key register the block derives the
// 52 decryption subkeys into a 52 x 16 RAM. Thirty-four of them come straight
// from the rotated key (plain or negated); the eighteen multiplicative
// inverses are raised to the power 65535 on the shared mod-65537 multiplier,
// with o_stall high while the schedule runs.
// A ciphertext transaction then runs from acceptance as sixty multiply, add
// or mix steps, one per cycle, seven per round over eight rounds and four
// for the output transform; the result is then loaded into the output
// register once that register is free. Every step but the mix reads one
// subkey from the RAM. The single multiplier and the one RAM read port are
// why the steps run one at a time. One block is worked on at a time; a
// finished block waits in the output register while the next is accepted.
// restart_chain chains from the IV register, else from the previous
// ciphertext. Key writes keep the chaining value; IV writes affect only
// later restarts. Writes to an index past the register list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_cbc_decryptor (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [icd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [icd_pkg::BLK_W-1:0]   i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [icd_pkg::BLK_W-1:0]   i_cipher_block,
    input  wire logic                        i_restart_chain,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [icd_pkg::BLK_W-1:0]   o_plain_block
);

    import icd_pkg::*;

    // control
    t_state r_state, n_state;
    logic [KEY_AW-1:0] r_j, n_j;          // subkey write address
    logic [3:0]        r_sr, n_sr;        // schedule round
    logic [2:0]        r_sp, n_sp;        // position in schedule round
    logic [3:0]        r_it, n_it;        // inverse iteration
    logic              r_ph, n_ph;        // inverse phase: multiply or square
    logic [3:0]        r_round, n_round;
    logic [2:0]        r_step, n_step;
    logic [KEY_AW-1:0] r_kidx, n_kidx;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic [15:0] r_acc, n_acc, r_base, n_base;
    logic [15:0] r_x1, n_x1, r_x2, n_x2, r_x3, n_x3, r_x4, n_x4;
    logic [15:0] r_t, n_t, r_u, n_u;
    logic [BLK_W-1:0] r_prev, n_prev, r_chain, n_chain;
    logic [BLK_W-1:0] r_out, n_out;
    logic [BLK_W-1:0] r_key_hi, r_key_lo, r_iv;

    // schedule helpers
    logic [5:0]  sr6, s_base, src;
    logic        swap;
    t_kop        kop;
    logic [15:0] ek;

    // shared multiplier and RAM
    logic [15:0] gm_a, gm_b, gm_y, k;
    logic [15:0] v;
    logic        ram_we;
    logic [15:0] ram_wdata;
    logic        key_wr;

    icd_ram #(
        .WIDTH (16),
        .DEPTH (KEY_CNT)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_j),
        .i_wdata (ram_wdata),
        .i_raddr (n_kidx),
        .o_rdata (k)
    );

    // Source subkey of the current decryption subkey.
    always_comb begin
        sr6    = {2'b00, r_sr};
        s_base = 6'd48 - ((sr6 << 2) + (sr6 << 1));
        swap   = (r_sr == 4'd0) || (r_sr == 4'd8);
        case (r_sp)
            3'd0: begin src = s_base;                        kop = KOP_INV;   end
            3'd1: begin src = s_base + (swap ? 6'd1 : 6'd2); kop = KOP_NEG;   end
            3'd2: begin src = s_base + (swap ? 6'd2 : 6'd1); kop = KOP_NEG;   end
            3'd3: begin src = s_base + 6'd3;                 kop = KOP_INV;   end
            3'd4: begin src = s_base - 6'd2;                 kop = KOP_PLAIN; end
            3'd5: begin src = s_base - 6'd1;                 kop = KOP_PLAIN; end
            default: begin src = s_base;                     kop = KOP_PLAIN; end
        endcase
        ek = f_ek({r_key_hi, r_key_lo}, src);
    end

    // Operand select for the one mod-65537 multiplier.
    always_comb begin
        gm_b = k;
        if (r_state == ST_INV) begin
            gm_a = r_ph ? r_base : r_acc;
            gm_b = r_base;
        end else begin
            case (r_step)
                3'd3:    gm_a = r_x4;
                3'd4:    gm_a = r_x3 ^ r_x1;
                3'd5:    gm_a = (r_x2 ^ r_x4) + r_t;
                default: gm_a = r_x1;
            endcase
        end
        gm_y = f_gmul(gm_a, gm_b);
    end

    assign v      = r_t + r_u;
    assign key_wr = i_cfg_we && ((i_cfg_index == CFG_KEY_HI) || (i_cfg_index == CFG_KEY_LO));

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_sr        = r_sr;
        n_sp        = r_sp;
        n_it        = r_it;
        n_ph        = r_ph;
        n_round     = r_round;
        n_step      = r_step;
        n_kidx      = r_kidx;
        n_acc       = r_acc;
        n_base      = r_base;
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_x3        = r_x3;
        n_x4        = r_x4;
        n_t         = r_t;
        n_u         = r_u;
        n_prev      = r_prev;
        n_chain     = r_chain;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;   // drop once taken
        ram_we      = 1'b0;
        ram_wdata   = ek;

        case (r_state)
            ST_KEY: begin
                if (kop == KOP_INV) begin
                    n_acc   = 16'h0001;
                    n_base  = ek;
                    n_it    = 4'd0;
                    n_ph    = 1'b0;
                    n_state = ST_INV;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = (kop == KOP_NEG) ? (16'h0000 - ek) : ek;
                end
            end
            ST_INV: begin
                // x^65535: multiply then square, sixteen times, with no square after the last multiply
                if (!r_ph) begin
                    n_acc = gm_y;
                    n_ph  = 1'b1;
                    if (r_it == 4'd15) begin
                        ram_we    = 1'b1;
                        ram_wdata = gm_y;
                    end
                end else begin
                    n_base = gm_y;
                    n_ph   = 1'b0;
                    n_it   = r_it + 4'd1;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_x1    = i_cipher_block[63:48];
                    n_x2    = i_cipher_block[47:32];
                    n_x3    = i_cipher_block[31:16];
                    n_x4    = i_cipher_block[15:0];
                    n_prev  = i_restart_chain ? r_iv : r_chain;
                    n_chain = i_cipher_block;
                    n_round = 4'd0;
                    n_step  = 3'd0;
                    n_kidx  = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_kidx = r_kidx + 1'b1;
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: n_x1 = gm_y;
                    3'd1: begin
                        if (r_round == 4'd8) begin
                            n_x3 = r_x3 + k;
                        end else begin
                            n_x2 = r_x2 + k;
                        end
                    end
                    3'd2: begin
                        if (r_round == 4'd8) begin
                            n_x2 = r_x2 + k;
                        end else begin
                            n_x3 = r_x3 + k;
                        end
                    end
                    3'd3: begin
                        n_x4 = gm_y;
                        if (r_round == 4'd8) begin
                            n_kidx  = r_kidx;
                            n_state = ST_DONE;
                        end
                    end
                    3'd4: n_t = gm_y;
                    3'd5: n_u = gm_y;
                    default: begin
                        // mix and swap, no subkey used
                        n_kidx  = r_kidx;
                        n_x1    = r_x1 ^ r_u;
                        n_x4    = r_x4 ^ v;
                        n_x2    = r_u ^ r_x3;
                        n_x3    = v ^ r_x2;
                        n_step  = 3'd0;
                        n_round = r_round + 4'd1;
                    end
                endcase
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out       = {r_x1, r_x3, r_x2, r_x4} ^ r_prev;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_KEY;
        endcase

        // advance the schedule after each subkey write
        if (ram_we) begin
            n_j     = r_j + 1'b1;
            n_state = ST_KEY;
            if ((r_sr == 4'd8) && (r_sp == 3'd3)) begin
                n_state = ST_IDLE;
            end else if (r_sp == 3'd5) begin
                n_sp = 3'd0;
                n_sr = r_sr + 4'd1;
            end else begin
                n_sp = r_sp + 3'd1;
            end
        end

        // a key write restarts the schedule
        if (key_wr) begin
            n_state = ST_KEY;
            n_j     = '0;
            n_sr    = 4'd0;
            n_sp    = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_KEY;
            r_j         <= '0;
            r_sr        <= 4'd0;
            r_sp        <= 3'd0;
            r_it        <= 4'd0;
            r_ph        <= 1'b0;
            r_round     <= 4'd0;
            r_step      <= 3'd0;
            r_kidx      <= '0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
            r_key_hi    <= '0;
            r_key_lo    <= '0;
            r_iv        <= '0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_sr        <= n_sr;
            r_sp        <= n_sp;
            r_it        <= n_it;
            r_ph        <= n_ph;
            r_round     <= n_round;
            r_step      <= n_step;
            r_kidx      <= n_kidx;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_HI: r_key_hi <= i_cfg_data;
                    CFG_KEY_LO: r_key_lo <= i_cfg_data;
                    CFG_IV:     r_iv     <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_x1   <= n_x1;
        r_x2   <= n_x2;
        r_x3   <= n_x3;
        r_x4   <= n_x4;
        r_t    <= n_t;
        r_u    <= n_u;
        r_prev <= n_prev;
        r_out  <= n_out;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_plain_block = r_out;

endmodule

`default_nettype wire

// ===== src/icd_checker.sv =====
// ----------------------------------------------------------------------------
// icd_checker
// Port-level checks for the IDEA CBC decryptor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "idea_cbc_decryptor_assert.svh"

module icd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cfg_we,
    input wire logic [icd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [icd_pkg::BLK_W-1:0]     o_plain_block
);

    import icd_pkg::*;

    // a waiting result holds
    `ICD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_plain_block))
    // one block at a time: a transaction closes the input
    `ICD_ASSERT_NEXT(a_one_at_a_time, i_valid && !o_stall, o_stall)
    // a key write starts a new schedule
    `ICD_ASSERT_NEXT(a_key_sched, i_cfg_we && ((i_cfg_index == CFG_KEY_HI) || (i_cfg_index == CFG_KEY_LO)), o_stall)

endmodule

bind idea_cbc_decryptor icd_checker u_icd_checker (.*);

`default_nettype wire

// ===== tb/idea_cbc_decryptor_tb.sv =====
// ----------------------------------------------------------------------------
// idea_cbc_decryptor_tb
// Self-checking bench for the IDEA CBC decryptor: a queue-fed driver, a
// receiver with random stalls, and a monitor that predicts every plaintext
// block from its own copy of the key schedule and chaining state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module idea_cbc_decryptor_tb;
    import icd_pkg::*;

    localparam t_cfg_idx CFG_NONE = 2'd3;   // index past the register list
    localparam int QUIET_LIMIT = 6000;      // cycles with no transaction at all
    localparam int SETTLE = 100;            // drain time before a register write

    typedef struct packed {
        logic [63:0] cblk;
        logic        restart;
    } t_cipher_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_index = CFG_KEY_HI;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_cipher_block = '0;
    logic        i_restart_chain = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_plain_block;

    idea_cbc_decryptor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cipher_block(i_cipher_block), .i_restart_chain(i_restart_chain),
        .o_valid(o_valid), .i_stall(i_stall), .o_plain_block(o_plain_block)
    );

    // Predictor state: key, IV, derived decryption subkeys, chaining block.
    logic [63:0] key_hi_m, key_lo_m, iv_m, chain_m;
    logic [15:0] dec_keys [52];

    t_cipher_item cipher_q [$];
    logic [63:0]  plain_q [$];

    int sent_cnt = 0, taken_cnt = 0, out_cnt = 0, restart_cnt = 0;
    int err_cnt = 0, quiet_cnt = 0, cfg_cnt = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int hold_gen = 0, hold_seen = 0, hold_left = 0, hold_len = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Multiply mod 65537, zero standing for 2^16.
    function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p, hi, lo, r;
        if (a == 0) return 16'(32'h10001 - b);
        if (b == 0) return 16'(32'h10001 - a);
        p  = a * b;
        hi = p >> 16;
        lo = p & 32'hffff;
        r  = (lo >= hi) ? lo - hi : 32'h10001 + lo - hi;
        return r[15:0];
    endfunction

    // Inverse by Fermat: x^(p-2) mod p.
    function automatic logic [15:0] inv_mod(input logic [15:0] x);
        logic [63:0] base, acc;
        int e;
        base = (x == 0) ? 64'd65536 : 64'(x);
        acc  = 1;
        e    = 65535;
        while (e != 0) begin
            if (e & 1) acc = (acc * base) % 65537;
            base = (base * base) % 65537;
            e = e >> 1;
        end
        return acc[15:0];
    endfunction

    // Expand the key, then invert into the decryption order.
    task automatic build_dec_keys();
        logic [15:0] ek [52];
        logic [63:0] hi, lo, nh, nl;
        int w, s, m;
        hi = key_hi_m;
        lo = key_lo_m;
        for (int i = 0; i < 52; i++) begin
            w = i % 8;
            if (w == 0 && i > 0) begin
                nh = (hi << 25) | (lo >> 39);
                nl = (lo << 25) | (hi >> 39);
                hi = nh;
                lo = nl;
            end
            if (w < 4) ek[i] = 16'(hi >> (48 - 16 * w));
            else       ek[i] = 16'(lo >> (48 - 16 * (w - 4)));
        end
        for (int r = 0; r < 8; r++) begin
            s = 6 * (8 - r);
            m = 6 * (7 - r);
            dec_keys[6*r]   = inv_mod(ek[s]);
            dec_keys[6*r+1] = -ek[s + ((r == 0) ? 1 : 2)];
            dec_keys[6*r+2] = -ek[s + ((r == 0) ? 2 : 1)];
            dec_keys[6*r+3] = inv_mod(ek[s+3]);
            dec_keys[6*r+4] = ek[m+4];
            dec_keys[6*r+5] = ek[m+5];
        end
        dec_keys[48] = inv_mod(ek[0]);
        dec_keys[49] = -ek[1];
        dec_keys[50] = -ek[2];
        dec_keys[51] = inv_mod(ek[3]);
    endtask

    function automatic logic [63:0] idea_decipher(input logic [63:0] blk);
        logic [15:0] x1, x2, x3, x4, s2, s3;
        int k;
        x1 = blk[63:48]; x2 = blk[47:32]; x3 = blk[31:16]; x4 = blk[15:0];
        k = 0;
        for (int r = 0; r < 8; r++) begin
            x1 = mul_mod(x1, dec_keys[k]);
            x2 = x2 + dec_keys[k+1];
            x3 = x3 + dec_keys[k+2];
            x4 = mul_mod(x4, dec_keys[k+3]);
            s3 = x3;
            s2 = x2;
            x3 = mul_mod(x3 ^ x1, dec_keys[k+4]);
            x2 = mul_mod(16'((x2 ^ x4) + x3), dec_keys[k+5]);
            x3 = x3 + x2;
            x1 = x1 ^ x2;
            x4 = x4 ^ x3;
            x2 = x2 ^ s3;
            x3 = x3 ^ s2;
            k += 6;
        end
        x1 = mul_mod(x1, dec_keys[48]);
        x3 = x3 + dec_keys[49];
        x2 = x2 + dec_keys[50];
        x4 = mul_mod(x4, dec_keys[51]);
        return {x1, x3, x2, x4};
    endfunction

    // Driver: advance to the next transaction only once the current one is taken.
    always @(negedge i_clk) begin
        if (taken_cnt == sent_cnt) begin
            if (cipher_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_cipher_item it;
                it = cipher_q.pop_front();
                i_cipher_block  <= it.cblk;
                i_restart_chain <= it.restart;
                i_valid         <= 1'b1;
                sent_cnt        <= sent_cnt + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge i_clk) begin
        if (hold_seen != hold_gen) begin
            hold_seen = hold_gen;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict on accepted input, check on accepted output.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                plain_q.push_back(idea_decipher(i_cipher_block)
                                  ^ (i_restart_chain ? iv_m : chain_m));
                chain_m = i_cipher_block;
                if (i_restart_chain) restart_cnt++;
                taken_cnt <= taken_cnt + 1;
            end
            if (o_valid && !i_stall) begin
                out_cnt++;
                if (plain_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected plaintext %h", o_plain_block);
                end else begin
                    logic [63:0] want;
                    want = plain_q.pop_front();
                    if (want !== o_plain_block) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("plaintext mismatch: expected %h, got %h",
                                     want, o_plain_block);
                    end
                end
            end
            // Watchdog: count cycles with no transaction on either side.
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cnt = 0;
            end else begin
                quiet_cnt++;
                if (quiet_cnt >= QUIET_LIMIT) begin
                    $display("watchdog expired, %0d blocks still expected", plain_q.size());
                    $display("idea_cbc_decryptor_tb: errors");
                    $finish;
                end
            end
        end
    end

    task automatic drain();
        while (cipher_q.size() != 0 || taken_cnt != sent_cnt || plain_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Write one register once all queued blocks are drained and mirror it in the predictor.
    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] val);
        drain();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_cnt++;
        case (idx)
            CFG_KEY_HI: begin key_hi_m = val; build_dec_keys(); end
            CFG_KEY_LO: begin key_lo_m = val; build_dec_keys(); end
            CFG_IV:     iv_m = val;
            default:    ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_block(input logic [63:0] c, input logic r);
        t_cipher_item it;
        it.cblk = c;
        it.restart = r;
        cipher_q.push_back(it);
    endtask

    initial begin
        int mode;
        logic [63:0] v;
        key_hi_m = '0; key_lo_m = '0; iv_m = '0; chain_m = '0;
        build_dec_keys();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: chain from zero after reset, field extremes, restarts.
        push_block(64'h0, 1'b0);
        push_block(64'hffff_ffff_ffff_ffff, 1'b0);
        push_block(64'h0, 1'b1);
        push_block(64'h0000_ffff_0000_ffff, 1'b0);
        push_block(64'hffff_0000_ffff_0000, 1'b1);
        push_block(64'h0001_0001_0001_0001, 1'b0);
        push_block(64'h8000_8000_8000_8000, 1'b0);
        push_block(64'h5555_aaaa_5555_aaaa, 1'b1);
        drain();
        cfg_write(CFG_IV, 64'hffff_ffff_ffff_ffff);
        push_block(64'h0123_4567_89ab_cdef, 1'b1);
        push_block(64'hfedc_ba98_7654_3210, 1'b0);
        // Key change in mid-message keeps the chaining block.
        cfg_write(CFG_KEY_HI, 64'hffff_ffff_ffff_ffff);
        cfg_write(CFG_KEY_LO, 64'hffff_ffff_ffff_ffff);
        push_block(64'h0, 1'b0);
        push_block(64'hffff_ffff_ffff_ffff, 1'b1);
        // Write to the unused index must change nothing.
        cfg_write(CFG_NONE, 64'hdead_beef_0bad_f00d);
        push_block(64'h1111_2222_3333_4444, 1'b0);
        push_block(64'h0, 1'b1);

        // Random phases under varying idle patterns and key settings.
        for (int p = 0; p < 8; p++) begin
            case (p)
                1:       begin cfg_write(CFG_KEY_HI, '0); cfg_write(CFG_KEY_LO, '0); end
                2:       cfg_write(CFG_IV, '0);
                3:       cfg_write(CFG_NONE, rand64());
                default: begin
                    cfg_write(CFG_KEY_HI, rand64());
                    cfg_write(CFG_KEY_LO, rand64());
                    cfg_write(CFG_IV, rand64());
                end
            endcase
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 52 : (mode == 3) ? 17 : 0;
            recv_stall_pct = (mode == 2) ? 52 : (mode == 3) ? 17 : 0;
            for (int n = 0; n < 60; n++) begin
                case ($urandom_range(15))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = rand64();
                endcase
                push_block(v, ($urandom_range(5) == 0));
            end
            // Hold the receiver off while items keep coming so the block backs up.
            if (p == 4) begin
                hold_len = 400;
                hold_gen++;
            end
        end
        drain();
        repeat (SETTLE) @(negedge i_clk);

        $display("covered %0d blocks (%0d restarts), %0d register writes, 4 idle patterns",
                 taken_cnt, restart_cnt, cfg_cnt);
        if (err_cnt == 0) begin
            $display("idea_cbc_decryptor_tb: clean");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("idea_cbc_decryptor_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/icd_pkg.sv
src/icd_ram.sv
src/idea_cbc_decryptor.sv
src/icd_checker.sv
tb/idea_cbc_decryptor_tb.sv
